@@ sv/adf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adf_pkg
// Shared types and constants for the API receive frame deframer.
// ----------------------------------------------------------------------------
package adf_pkg;

    localparam logic [7:0]  DELIM_BYTE   = 8'h7E;
    localparam logic [7:0]  ID_LONG_SRC  = 8'h80;
    localparam logic [7:0]  ID_SHORT_SRC = 8'h81;
    localparam logic [7:0]  SUM_GOOD     = 8'hFF;
    localparam logic [15:0] HDR_SHORT    = 16'd5;
    localparam logic [15:0] HDR_LONG     = 16'd11;
    localparam logic [15:0] ADDR_END_SHORT = 16'd3;
    localparam logic [15:0] ADDR_END_LONG  = 16'd9;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'hFFFF;

    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam logic REG_MAX_PAYLOAD = 1'b0;

    localparam int OUT_TDATA_W = 96;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_LENHI = 3'd1,
        PH_LENLO = 3'd2,
        PH_BODY  = 3'd3,
        PH_CSUM  = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_STRAY     = 3'd1,
        ST_ZERO_LEN  = 3'd2,
        ST_BAD_CSUM  = 3'd3,
        ST_UNKNOWN_ID = 3'd4,
        ST_TOO_SHORT = 3'd5
    } status_t;

    typedef struct packed {
        logic [15:0] payload_length;
        logic        address_is_long;
        logic [63:0] source_address;
        logic [2:0]  status;
        logic [7:0]  data_byte;
        logic        is_end;
    } result_t;

endpackage

@@ sv/adf_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adf_cfg_regs
// APB register bank holding the payload forwarding limit.
// ----------------------------------------------------------------------------
module adf_cfg_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [adf_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [adf_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [adf_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output logic [15:0]                       max_payload_len
);

    logic [15:0] max_payload_len_reg;
    logic [15:0] max_payload_len_next;
    logic        reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == adf_pkg::REG_MAX_PAYLOAD);

    always_comb
    begin
        max_payload_len_next = max_payload_len_reg;
        if (psel && penable && pwrite && pready && reg_sel)
        begin
            max_payload_len_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_len_reg <= adf_pkg::MAX_PAYLOAD_RESET;
        end
        else
        begin
            max_payload_len_reg <= max_payload_len_next;
        end
    end

    assign prdata = reg_sel ? {16'd0, max_payload_len_reg} : '0;
    assign max_payload_len = max_payload_len_reg;

endmodule

@@ sv/adf_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adf_parser
// Input byte register and per-byte frame state machine.
// ----------------------------------------------------------------------------
module adf_parser
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [7:0]       in_byte,
    output logic             in_ready,
    input  logic [15:0]      max_payload_len,
    input  logic             res_space,
    output logic             res_push,
    output adf_pkg::result_t res
);

    logic                in_valid_reg;
    logic                in_valid_next;
    logic [7:0]          in_byte_reg;
    logic                advance;

    adf_pkg::phase_t     phase_reg;
    adf_pkg::phase_t     phase_next;
    logic [15:0]         frame_length_reg;
    logic [15:0]         frame_length_next;
    logic [15:0]         body_count_reg;
    logic [15:0]         body_count_next;
    logic [7:0]          running_sum_reg;
    logic [7:0]          running_sum_next;
    logic [7:0]          api_id_reg;
    logic [7:0]          api_id_next;
    logic [63:0]         captured_address_reg;
    logic [63:0]         captured_address_next;
    logic [7:0]          length_high_reg;
    logic [7:0]          length_high_next;

    logic [7:0]          b;
    logic                id_short;
    logic                id_long;
    logic [15:0]         hdr;
    logic [15:0]         addr_end;
    logic [15:0]         pos_plus;
    logic [15:0]         new_length;
    logic [7:0]          total;
    logic                produce;
    adf_pkg::result_t    res_c;

    assign advance  = in_valid_reg && res_space;
    assign in_ready = !in_valid_reg || res_space;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_ready)
        begin
            in_valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= in_byte;
        end
    end

    assign b          = in_byte_reg;
    assign id_short   = (api_id_reg == adf_pkg::ID_SHORT_SRC);
    assign id_long    = (api_id_reg == adf_pkg::ID_LONG_SRC);
    assign hdr        = id_long ? adf_pkg::HDR_LONG : adf_pkg::HDR_SHORT;
    assign addr_end   = id_short ? adf_pkg::ADDR_END_SHORT : adf_pkg::ADDR_END_LONG;
    assign pos_plus   = body_count_reg + 16'd1;
    assign new_length = {length_high_reg, b};
    assign total      = running_sum_reg + b;

    always_comb
    begin
        phase_next            = phase_reg;
        frame_length_next     = frame_length_reg;
        body_count_next       = body_count_reg;
        running_sum_next      = running_sum_reg;
        api_id_next           = api_id_reg;
        captured_address_next = captured_address_reg;
        length_high_next      = length_high_reg;
        produce               = 1'b0;
        res_c                 = '0;

        case (phase_reg)
            adf_pkg::PH_HUNT:
            begin
                if (b == adf_pkg::DELIM_BYTE)
                begin
                    phase_next = adf_pkg::PH_LENHI;
                end
                else
                begin
                    produce      = 1'b1;
                    res_c.is_end = 1'b1;
                    res_c.status = adf_pkg::ST_STRAY;
                end
            end
            adf_pkg::PH_LENHI:
            begin
                length_high_next = b;
                phase_next       = adf_pkg::PH_LENLO;
            end
            adf_pkg::PH_LENLO:
            begin
                frame_length_next = new_length;
                if (new_length == 16'd0)
                begin
                    phase_next   = adf_pkg::PH_HUNT;
                    produce      = 1'b1;
                    res_c.is_end = 1'b1;
                    res_c.status = adf_pkg::ST_ZERO_LEN;
                end
                else
                begin
                    body_count_next       = '0;
                    running_sum_next      = '0;
                    api_id_next           = '0;
                    captured_address_next = '0;
                    phase_next            = adf_pkg::PH_BODY;
                end
            end
            adf_pkg::PH_BODY:
            begin
                running_sum_next = total;
                if (body_count_reg == 16'd0)
                begin
                    api_id_next = b;
                end
                else if (id_short || id_long)
                begin
                    if (body_count_reg < addr_end)
                    begin
                        captured_address_next = {captured_address_reg[55:0], b};
                    end
                    else if (body_count_reg >= hdr &&
                             (body_count_reg - hdr) < max_payload_len)
                    begin
                        produce         = 1'b1;
                        res_c.data_byte = b;
                    end
                end
                body_count_next = pos_plus;
                if (pos_plus == frame_length_reg)
                begin
                    phase_next = adf_pkg::PH_CSUM;
                end
            end
            adf_pkg::PH_CSUM:
            begin
                phase_next   = adf_pkg::PH_HUNT;
                produce      = 1'b1;
                res_c.is_end = 1'b1;
                if (total != adf_pkg::SUM_GOOD)
                begin
                    res_c.status = adf_pkg::ST_BAD_CSUM;
                end
                else if (!id_short && !id_long)
                begin
                    res_c.status = adf_pkg::ST_UNKNOWN_ID;
                end
                else if (frame_length_reg < hdr)
                begin
                    res_c.status = adf_pkg::ST_TOO_SHORT;
                end
                else
                begin
                    res_c.status          = adf_pkg::ST_OK;
                    res_c.source_address  = captured_address_reg;
                    res_c.address_is_long = id_long;
                    res_c.payload_length  = frame_length_reg - hdr;
                end
            end
            default:
            begin
                phase_next = adf_pkg::PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= adf_pkg::PH_HUNT;
            frame_length_reg     <= '0;
            body_count_reg       <= '0;
            running_sum_reg      <= '0;
            api_id_reg           <= '0;
            captured_address_reg <= '0;
            length_high_reg      <= '0;
        end
        else if (advance)
        begin
            phase_reg            <= phase_next;
            frame_length_reg     <= frame_length_next;
            body_count_reg       <= body_count_next;
            running_sum_reg      <= running_sum_next;
            api_id_reg           <= api_id_next;
            captured_address_reg <= captured_address_next;
            length_high_reg      <= length_high_next;
        end
    end

    assign res_push = advance && produce;
    assign res      = res_c;

endmodule

@@ sv/adf_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adf_out_reg
// Result register driving the master-side stream.
// ----------------------------------------------------------------------------
module adf_out_reg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                res_push,
    input  adf_pkg::result_t                    res,
    output logic                                res_space,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [adf_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                m_tuser
);

    logic             valid_reg;
    logic             valid_next;
    adf_pkg::result_t res_reg;

    assign res_space = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_push)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.is_end;
    assign m_tdata  = {4'd0, res_reg.payload_length, res_reg.address_is_long,
                       res_reg.source_address, res_reg.status, res_reg.data_byte};

endmodule

@@ sv/api_rx_frame_deframer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// api_rx_frame_deframer_core
// Receive-side deframer for API-mode serial radio frames.
// ----------------------------------------------------------------------------
// Slave stream: one received byte per transfer on s_tdata.
// Master stream: one result per transfer; m_tuser low carries a payload
//   byte, m_tuser high an end or error status with source address and
//   payload length (valid on an ok status only).
// APB port: register 0 at address 0 sets the payload forwarding limit.
// Path: an accepted byte waits in the input register; its result is loaded
//   into the result register when the state update advances.
// Throughput: one byte per cycle while no result is held, set by the state
//   update between the input and result registers.
// Reset: clears the frame state to delimiter hunt, empties both registers
//   and sets the limit to 65535.
// Stall: a held result stops the state update; s_tready falls once the
//   input register is also full and rises again as soon as m_tready returns.
// Discard payload bytes of a frame whose end status is not ok.
// ----------------------------------------------------------------------------
module api_rx_frame_deframer_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,  // [7:0] rx_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] data_byte, [10:8] status, [74:11] source_address,
    // [75] address_is_long, [91:76] payload_length, [95:92] zero
    output logic [adf_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                m_tuser,  // [0] is_end
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [adf_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [adf_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [adf_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    logic             res_space;
    logic             res_push;
    logic [15:0]      max_payload_len;
    adf_pkg::result_t res;

    adf_cfg_regs u_cfg
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .max_payload_len (max_payload_len)
    );

    adf_parser u_parser
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_tvalid),
        .in_byte         (s_tdata),
        .in_ready        (s_tready),
        .max_payload_len (max_payload_len),
        .res_space       (res_space),
        .res_push        (res_push),
        .res             (res)
    );

    adf_out_reg u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_push  (res_push),
        .res       (res),
        .res_space (res_space),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
